// File: sv/esp_pkg.sv
// Shared types and constants of the encoder period speed estimator.
// Holds field widths, register indexes, status codes and the
// controller/datapath interface structs. No dependencies.
package esp_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int CH_W         = 1;
  localparam int STAMP_W      = 32;
  localparam int CLK_W        = 26;
  localparam int PPR_W        = 12;
  localparam int LIM_W        = 4;
  localparam int SPEED_W      = 20;
  localparam int STAT_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = CLK_W;
  localparam int DEN_W        = STAMP_W + PPR_W;
  localparam int LIMP_W       = DEN_W + LIM_W;
  localparam int FRAC_W       = 16;
  localparam int NUM_W        = CLK_W + FRAC_W;
  localparam int DIV_STEPS    = SPEED_W;
  localparam int CNT_W        = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PPR      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd2;

  localparam logic [CLK_W-1:0] CLOCK_HZ_RST = CLK_W'(16000000);
  localparam logic [PPR_W-1:0] PPR_RST      = PPR_W'(245);
  localparam logic [LIM_W-1:0] LIMIT_RST    = LIM_W'(10);

  localparam logic [STAT_W-1:0] ST_UPDATED = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_DISCARD = 2'd2;

  typedef struct packed {
    logic load;
    logic mul;
    logic chk;
    logic div_step;
    logic finish;
  } esp_cmd_t;

  typedef struct packed {
    logic skip_div;
    logic out_free;
  } esp_sts_t;

endpackage

// File: sv/esp_ctrl.sv
// Controller state machine of the speed estimator.
// Sequences capture, multiply, limit check, the divider and the result write.
// Depends on esp_pkg.
module esp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  esp_pkg::esp_sts_t sts_i,
  output esp_pkg::esp_cmd_t cmd_o
);
  import esp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        cnt_d     = '0;
        state_d   = sts_i.skip_div ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q < CNT_W'(DIV_STEPS))
    else $error("divider step count out of range");

  a_load_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_MUL)
    else $error("captured transaction did not enter the multiply step");

  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && !sts_i.out_free |=> state_q == S_DONE)
    else $error("result dropped while the output register was busy");

endmodule

// File: sv/esp_datapath.sv
// Datapath of the speed estimator: per-channel stamp and speed state,
// interval multiply, limit check, bit-serial divider, filter and output register.
// Depends on esp_pkg.
module esp_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  esp_pkg::esp_cmd_t             cmd_i,
  output esp_pkg::esp_sts_t             sts_o,
  input  logic [esp_pkg::CH_W-1:0]      channel_i,
  input  logic [esp_pkg::STAMP_W-1:0]   edge_stamp_i,
  input  logic [esp_pkg::CLK_W-1:0]     clock_hz_i,
  input  logic [esp_pkg::PPR_W-1:0]     ppr_i,
  input  logic [esp_pkg::LIM_W-1:0]     limit_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [esp_pkg::CH_W-1:0]      out_channel_o,
  output logic [esp_pkg::SPEED_W-1:0]   speed_q4_16_o,
  output logic [esp_pkg::STAT_W-1:0]    status_o
);
  import esp_pkg::*;

  logic [STAMP_W-1:0] stamp_q [NUM_CHANNELS];
  logic [SPEED_W-1:0] filt_q  [NUM_CHANNELS];

  logic [CH_W-1:0]    ch_q;
  logic               ch_ok_q;
  logic [STAMP_W-1:0] interval_q;
  logic [DEN_W-1:0]   den_q;
  logic [STAT_W-1:0]  stat_q;
  logic [DEN_W-1:0]   rem_q;
  logic [SPEED_W-1:0] nq_q;

  logic               out_valid_q;
  logic [CH_W-1:0]    out_ch_q;
  logic [SPEED_W-1:0] out_speed_q;
  logic [STAT_W-1:0]  out_stat_q;

  logic               in_ch_ok;
  logic [LIMP_W-1:0]  lim_prod;
  logic               discard;
  logic [STAT_W-1:0]  chk_stat;
  logic [DEN_W:0]     trial;
  logic [DEN_W:0]     diff;
  logic               ge;
  logic [SPEED_W-1:0] old_speed;
  logic [SPEED_W:0]   sum;
  logic [SPEED_W-1:0] new_speed;

  assign in_ch_ok = (int'(channel_i) < NUM_CHANNELS);

  assign lim_prod = LIMP_W'(limit_i) * LIMP_W'(den_q);
  assign discard  = (den_q == '0) || (LIMP_W'(clock_hz_i) >= lim_prod);

  always_comb begin
    if (!ch_ok_q || interval_q == '0) begin
      chk_stat = ST_IGNORED;
    end else if (discard) begin
      chk_stat = ST_DISCARD;
    end else begin
      chk_stat = ST_UPDATED;
    end
  end

  assign trial = {rem_q, nq_q[SPEED_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  assign old_speed = ch_ok_q ? filt_q[ch_q] : '0;
  assign sum       = {1'b0, old_speed} + {1'b0, nq_q};
  assign new_speed = sum[SPEED_W:1];

  assign sts_o.skip_div = (chk_stat != ST_UPDATED);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        stamp_q[i] <= '0;
        filt_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.load && in_ch_ok) begin
        stamp_q[channel_i] <= edge_stamp_i;
      end
      if (cmd_i.finish && stat_q == ST_UPDATED) begin
        filt_q[ch_q] <= new_speed;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q       <= channel_i;
      ch_ok_q    <= in_ch_ok;
      interval_q <= in_ch_ok ? (edge_stamp_i - stamp_q[channel_i]) : '0;
    end
    if (cmd_i.mul) begin
      den_q <= DEN_W'(interval_q) * DEN_W'(ppr_i);
    end
    if (cmd_i.chk) begin
      stat_q <= chk_stat;
      rem_q  <= DEN_W'(clock_hz_i[CLK_W-1:SPEED_W-FRAC_W]);
      nq_q   <= {clock_hz_i[SPEED_W-FRAC_W-1:0], FRAC_W'(0)};
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nq_q  <= {nq_q[SPEED_W-2:0], ge};
    end
    if (cmd_i.finish) begin
      out_ch_q    <= ch_q;
      out_stat_q  <= stat_q;
      out_speed_q <= (stat_q == ST_UPDATED) ? new_speed : old_speed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign speed_q4_16_o = out_speed_q;
  assign status_o      = out_stat_q;

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while a result was stalled");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && stat_q == ST_UPDATED |-> rem_q < den_q)
    else $error("divider remainder not below the divisor");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q)
    else $error("stalled result transaction withdrawn");

endmodule

// File: sv/encoder_period_speed_estimator.sv
// Encoder period speed estimator, top level: configuration registers,
// controller and datapath. Depends on esp_pkg, esp_ctrl and esp_datapath.
// Each accepted transaction passes multiply and limit check; a valid interval within
// the limit then runs 20 restoring divider steps before the result write, any other
// skips the divider. No new transaction is accepted until the result is written, and
// the write waits while a stalled result holds the output register. Reset is asynchronous
// active low; it clears per-channel state and loads the default configuration.
module encoder_period_speed_estimator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [esp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [esp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [esp_pkg::CH_W-1:0]        channel_i,
  input  logic [esp_pkg::STAMP_W-1:0]     edge_stamp_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [esp_pkg::CH_W-1:0]        out_channel_o,
  output logic [esp_pkg::SPEED_W-1:0]     speed_q4_16_o,
  output logic [esp_pkg::STAT_W-1:0]      status_o
);
  import esp_pkg::*;

  logic [CLK_W-1:0] clock_hz_q;
  logic [PPR_W-1:0] ppr_q;
  logic [LIM_W-1:0] limit_q;
  esp_cmd_t         cmd;
  esp_sts_t         sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= CLOCK_HZ_RST;
      ppr_q      <= PPR_RST;
      limit_q    <= LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CLOCK_HZ: clock_hz_q <= cfg_data_i[CLK_W-1:0];
        CFG_PPR:      ppr_q      <= cfg_data_i[PPR_W-1:0];
        CFG_LIMIT:    limit_q    <= cfg_data_i[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  esp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  esp_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .channel_i     (channel_i),
    .edge_stamp_i  (edge_stamp_i),
    .clock_hz_i    (clock_hz_q),
    .ppr_i         (ppr_q),
    .limit_i       (limit_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_channel_o (out_channel_o),
    .speed_q4_16_o (speed_q4_16_o),
    .status_o      (status_o)
  );

endmodule
